// File: hw/rtl/sha512_hash_core_macros.svh
// Assertion macros for the SHA-512 hash core
`ifndef SHA512_HASH_CORE_MACROS_SVH
`define SHA512_HASH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/sha512_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

  typedef struct packed {
    logic [63:0] msg_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       take_word;   // store a full message word
    logic       pad_start;   // build padded tail
    logic       round_init;  // load working vars from chain
    logic       round_step;  // one compression round
    logic [6:0] round_idx;
    logic       fold;        // add working vars into chain
    logic       second_blk;  // load second tail block
    logic       chain_reset; // back to initial hash
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic block_full;
    logic two_blocks;
  } dp_sts_t;

  localparam logic [63:0] INIT_H [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha512_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sha512_hash_core_macros.svh"
module sha512_ctrl
  import sha512_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_item_t  in_data,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [2:0]     emit_idx,
  output dp_cmd_t        cmd,
  input  wire dp_sts_t   sts
);

  ctl_state_t state_r, state_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic       final_r, final_nxt;   // compressing a padded tail, low until its first block
  logic       second_r, second_nxt; // second tail block pending
  logic [2:0] emit_r, emit_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rnd_r    <= '0;
      final_r  <= 1'b0;
      second_r <= 1'b0;
      emit_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      final_r  <= final_nxt;
      second_r <= second_nxt;
      emit_r   <= emit_nxt;
    end
  end

  // Advance sequencer
  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    final_nxt  = final_r;
    second_nxt = second_r;
    emit_nxt   = emit_r;
    cmd        = '0;
    cmd.round_idx = rnd_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.last_word) begin
            cmd.pad_start = 1'b1;
            final_nxt = 1'b0;
            state_nxt = ST_PAD;
          end else begin
            cmd.take_word = 1'b1;
            if (sts.block_full) begin
              cmd.round_init = 1'b1;
              final_nxt = 1'b0;
              rnd_nxt = '0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.round_init = 1'b1;
        // Latch the block count only on entry to the first tail block
        if (!final_r) second_nxt = sts.two_blocks;
        final_nxt  = 1'b1;
        rnd_nxt    = '0;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!final_r) begin
          state_nxt = ST_IDLE;
        end else if (second_r) begin
          cmd.second_blk = 1'b1;
          second_nxt = 1'b0;
          state_nxt  = ST_PAD;
        end else begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emit_nxt = emit_r + 3'd1;
          if (emit_r == 3'd7) begin
            cmd.chain_reset = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign emit_idx = emit_r;

  `SHA_ASSERT_IMP(a_rnd_range, clk, rst_n, state_r == ST_ROUND, rnd_r <= 7'd79)
  `SHA_ASSERT_NXT(a_round_to_fold, clk, rst_n, state_r == ST_ROUND && rnd_r == 7'd79,
                  state_r == ST_FOLD)
  `SHA_ASSERT_IMP(a_no_emit_busy, clk, rst_n, out_valid, !in_ready)
  `SHA_ASSERT_NXT(a_emit_done, clk, rst_n,
                  state_r == ST_EMIT && out_ready && emit_r == 3'd7, state_r == ST_IDLE)

endmodule
`default_nettype wire

// File: hw/rtl/sha512_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module sha512_dpath
  import sha512_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire dp_cmd_t   cmd,
  input  wire logic [2:0] emit_idx,
  output dp_sts_t        sts,
  output logic [63:0]    digest_word
);

  logic [63:0] buf_r [16];   // message block, undefined until written
  logic [3:0]  widx_r, widx_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] chain_r [8];
  logic [63:0] v_r [8];
  logic [63:0] w_r [16];     // schedule window, w_r[0] is current
  logic [63:0] tail2_r;      // length word for second block
  logic        two_r;
  logic        lead_r;       // padding byte opens the second block

  logic [3:0]  nv;
  logic [63:0] keep, padded, new_w, t1, t2, e, a;
  logic [63:0] s0, s1;
  logic [63:0] tail_w [16];
  logic [7:0]  tail_pos;
  logic        two_blk;
  logic [63:0] len_w;

  assign nv = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
  assign keep = (nv == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nv, 3'b000});
  assign padded = (nv == 4'd8) ? in_data.msg_word
                : ((in_data.msg_word & keep) | (64'h80 << (7'd56 - {nv, 3'b000})));

  // Size the padded tail
  assign tail_pos = {1'b0, widx_r, 3'b000} + {4'b0000, nv};
  assign two_blk  = (tail_pos >= 8'd112);
  assign len_w    = bits_r + {57'd0, nv, 3'b000};

  // Build the first tail block ahead of the length word
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (i < widx_r) tail_w[i] = buf_r[i];
      else if (i == widx_r) tail_w[i] = padded;
      else if (i == widx_r + 1 && nv == 4'd8) tail_w[i] = 64'h8000000000000000;
      else tail_w[i] = '0;
    end
  end

  assign sts.block_full = (widx_r == 4'd15);
  assign sts.two_blocks = two_r;

  // Hold counters
  always_comb begin
    widx_nxt = widx_r;
    bits_nxt = bits_r;
    if (cmd.take_word) begin
      widx_nxt = widx_r + 4'd1;
      bits_nxt = bits_r + 64'd64;
    end
    if (cmd.pad_start || cmd.chain_reset) begin
      widx_nxt = '0;
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      bits_r <= '0;
    end else begin
      widx_r <= widx_nxt;
      bits_r <= bits_nxt;
    end
  end

  // Schedule and round logic
  assign s0 = ror64(w_r[1], 1) ^ ror64(w_r[1], 8) ^ (w_r[1] >> 7);
  assign s1 = ror64(w_r[14], 19) ^ ror64(w_r[14], 61) ^ (w_r[14] >> 6);
  assign new_w = s1 + w_r[9] + s0 + w_r[0];
  assign e = v_r[4];
  assign a = v_r[0];
  assign t1 = v_r[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[cmd.round_idx] + w_r[0];
  assign t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_reset) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= INIT_H[i];
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
    end
  end

  // Buffer, schedule window and working variables
  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      buf_r[widx_r] <= in_data.msg_word;
      if (widx_r == 4'd15) begin
        for (int i = 0; i < 15; i++) w_r[i] <= buf_r[i];
        w_r[15] <= in_data.msg_word;
      end
    end
    if (cmd.pad_start) begin
      for (int i = 0; i < 15; i++) w_r[i] <= tail_w[i];
      w_r[15] <= two_blk ? tail_w[15] : len_w;
      two_r   <= two_blk;
      lead_r  <= (widx_r == 4'd15) && (nv == 4'd8);
      tail2_r <= len_w;
    end
    if (cmd.second_blk) begin
      w_r[0] <= lead_r ? 64'h8000000000000000 : 64'd0;
      for (int i = 1; i < 15; i++) w_r[i] <= '0;
      w_r[15] <= tail2_r;
    end
    if (cmd.round_init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end
    if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= new_w;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  assign digest_word = chain_r[emit_idx];

endmodule
`default_nettype wire

// File: hw/rtl/sha512_hash_core.sv
// channel | direction | payload       | handshake
// in_     | input     | in_item_t     | in_valid / in_ready
// out_    | output    | out_item_t    | out_valid / out_ready
// A non-last word is stored in the block buffer; the sixteenth starts 80 rounds plus a fold.
// A last word takes pad, 80 rounds and fold per tail block (one or two), then 8 outputs.
// Rate is set by the single shared round unit: one round per cycle.
// Reset loads the initial hash and clears the word and bit counters.
// Output stalls hold the digest in place; no input is taken until all 8 words leave.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_core
  import sha512_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  emit_idx;
  logic [63:0] dword;

  sha512_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_data, .in_ready, .out_valid, .out_ready,
    .emit_idx, .cmd, .sts
  );

  sha512_dpath u_dpath (
    .clk, .rst_n, .in_data, .cmd, .emit_idx, .sts, .digest_word(dword)
  );

  assign out_data.digest_word = dword;
  assign out_data.word_index  = emit_idx;
  assign out_data.digest_last = (emit_idx == 3'd7);

endmodule
`default_nettype wire
